[sv/rtqs_pkg.sv]
package rtqs_pkg;

  localparam int CAP    = 16;
  localparam int CB     = 16;
  localparam int DW     = CB + 1;
  localparam int AW     = 2 * DW;
  localparam int WW     = AW + 2;
  localparam int IDX_W  = $clog2(CAP);
  localparam int CNT_W  = $clog2(CAP + 1);

  typedef struct packed {
    logic signed [CB-1:0] min_x;
    logic signed [CB-1:0] min_y;
    logic signed [CB-1:0] max_x;
    logic signed [CB-1:0] max_y;
  } box_t;

  // best candidate travelling down the row of cells
  typedef struct packed {
    logic                 found;
    logic                 two;
    logic signed [WW-1:0] key;
    logic [IDX_W-1:0]     ia;
    logic [IDX_W-1:0]     ib;
    box_t                 ba;
    box_t                 bb;
  } pkt_t;

  // broadcast to every cell
  typedef struct packed {
    logic                 seed;
    logic [IDX_W-1:0]     probe;
    box_t                 x;
    box_t                 y;
    logic signed [WW-1:0] k;
  } ctl_t;

  function automatic box_t box_join(box_t a, box_t b);
    box_t r;
    r.min_x = (a.min_x < b.min_x) ? a.min_x : b.min_x;
    r.min_y = (a.min_y < b.min_y) ? a.min_y : b.min_y;
    r.max_x = (a.max_x > b.max_x) ? a.max_x : b.max_x;
    r.max_y = (a.max_y > b.max_y) ? a.max_y : b.max_y;
    return r;
  endfunction

  function automatic logic signed [AW-1:0] box_area(box_t b);
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [AW-1:0] p;
    dx = DW'(b.max_x) - DW'(b.min_x);
    dy = DW'(b.max_y) - DW'(b.min_y);
    p  = AW'(dx) * AW'(dy);
    return p;
  endfunction

endpackage

[sv/rtqs_cell.sv]
module rtqs_cell (
  input  logic                                clk,
  input  logic                                wr_en,
  input  rtqs_pkg::box_t                      wr_box,
  input  logic signed [rtqs_pkg::AW-1:0]      wr_area,
  input  logic [rtqs_pkg::IDX_W-1:0]          my_idx,
  input  logic                                elig,
  input  rtqs_pkg::ctl_t                      ctl,
  input  rtqs_pkg::pkt_t                      pkt_in,
  output rtqs_pkg::pkt_t                      pkt_out,
  output rtqs_pkg::box_t                      box_o,
  output logic signed [rtqs_pkg::AW-1:0]      area_o
);

  rtqs_pkg::box_t                   box_r;
  logic signed [rtqs_pkg::AW-1:0]   area_r;
  logic signed [rtqs_pkg::WW-1:0]   key_r, key_nxt;
  logic                             neg_r;
  rtqs_pkg::pkt_t                   pkt_r, pkt_nxt;

  logic signed [rtqs_pkg::AW-1:0]   m1, m2;
  logic signed [rtqs_pkg::WW-1:0]   met, sub2;

  always_comb begin
    m1   = rtqs_pkg::box_area(rtqs_pkg::box_join(ctl.x, box_r));
    m2   = rtqs_pkg::box_area(rtqs_pkg::box_join(ctl.y, box_r));
    sub2 = ctl.seed ? rtqs_pkg::WW'(area_r) : rtqs_pkg::WW'(m2);
    met  = rtqs_pkg::WW'(m1) - sub2 + ctl.k;
    if (ctl.seed || !met[rtqs_pkg::WW-1]) begin
      key_nxt = met;
    end else begin
      key_nxt = -met;
    end
  end

  always_comb begin
    pkt_nxt = pkt_in;
    if (elig && (!pkt_in.found || key_r > pkt_in.key)) begin
      pkt_nxt.found = 1'b1;
      pkt_nxt.two   = !neg_r;
      pkt_nxt.key   = key_r;
      pkt_nxt.ia    = ctl.probe;
      pkt_nxt.ib    = my_idx;
      pkt_nxt.ba    = ctl.x;
      pkt_nxt.bb    = box_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      box_r  <= wr_box;
      area_r <= wr_area;
    end
    key_r <= key_nxt;
    neg_r <= met[rtqs_pkg::WW-1];
    pkt_r <= pkt_nxt;
  end

  assign pkt_out = pkt_r;
  assign box_o   = box_r;
  assign area_o  = area_r;

endmodule

[sv/rtree_quadratic_node_split.sv]
// Loading: one item per cycle, no result until the item with last_entry.
// Split of n >= 2 entries: seed search over every pair, then the two seeds,
// then each remaining entry in turn, CAP = 16 cells; a single entry goes out alone.
// busy is high while the split runs and results come out as single-cycle strobes.
// The receiver cannot stall. rst_n (synchronous) returns to loading with an
// empty node; stored boxes are not cleared.
module rtree_quadratic_node_split (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [rtqs_pkg::CB-1:0]  in_box_min_x,
  input  logic signed [rtqs_pkg::CB-1:0]  in_box_min_y,
  input  logic signed [rtqs_pkg::CB-1:0]  in_box_max_x,
  input  logic signed [rtqs_pkg::CB-1:0]  in_box_max_y,
  input  logic                            in_last_entry,
  output logic                            out_valid,
  output logic [rtqs_pkg::IDX_W-1:0]      out_entry_index,
  output logic                            out_to_group_two,
  output logic signed [rtqs_pkg::CB-1:0]  out_one_min_x,
  output logic signed [rtqs_pkg::CB-1:0]  out_one_min_y,
  output logic signed [rtqs_pkg::CB-1:0]  out_one_max_x,
  output logic signed [rtqs_pkg::CB-1:0]  out_one_max_y,
  output logic signed [rtqs_pkg::CB-1:0]  out_two_min_x,
  output logic signed [rtqs_pkg::CB-1:0]  out_two_min_y,
  output logic signed [rtqs_pkg::CB-1:0]  out_two_max_x,
  output logic signed [rtqs_pkg::CB-1:0]  out_two_max_y,
  output logic                            out_last_result
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_ONE   = 4'd1;
  localparam logic [3:0] S_SMET  = 4'd2;
  localparam logic [3:0] S_SRUN  = 4'd3;
  localparam logic [3:0] S_SNEXT = 4'd4;
  localparam logic [3:0] S_SEED1 = 4'd5;
  localparam logic [3:0] S_SEED2 = 4'd6;
  localparam logic [3:0] S_AAREA = 4'd7;
  localparam logic [3:0] S_AMET  = 4'd8;
  localparam logic [3:0] S_ARUN  = 4'd9;
  localparam logic [3:0] S_AEMIT = 4'd10;

  localparam int CAP   = rtqs_pkg::CAP;
  localparam int IDX_W = rtqs_pkg::IDX_W;
  localparam int CNT_W = rtqs_pkg::CNT_W;
  localparam int AW    = rtqs_pkg::AW;
  localparam int WW    = rtqs_pkg::WW;

  logic [3:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  placed_r, placed_nxt;
  logic [IDX_W-1:0]  probe_r, probe_nxt;
  logic [IDX_W-1:0]  cyc_r, cyc_nxt;
  logic [CAP-1:0]    asg_r, asg_nxt;
  rtqs_pkg::pkt_t    carry_r, carry_nxt;
  rtqs_pkg::box_t    g1_r, g1_nxt, g2_r, g2_nxt;
  logic signed [AW-1:0] a1_r, a1_nxt, a2_r, a2_nxt;

  logic              ov_r, ov_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic              otwo_r, otwo_nxt;
  logic              olast_r, olast_nxt;
  rtqs_pkg::box_t    ob1_r, ob1_nxt, ob2_r, ob2_nxt;

  rtqs_pkg::box_t       in_box, jbox;
  logic signed [AW-1:0] in_area;
  logic                 accept, room;
  logic [CAP-1:0]       elig;
  rtqs_pkg::ctl_t       ctl;
  rtqs_pkg::pkt_t       chain [CAP+1];
  rtqs_pkg::box_t       cbox  [CAP];
  logic signed [AW-1:0] carea [CAP];
  rtqs_pkg::pkt_t       null_pkt, last_pkt;

  assign in_box.min_x = in_box_min_x;
  assign in_box.min_y = in_box_min_y;
  assign in_box.max_x = in_box_max_x;
  assign in_box.max_y = in_box_max_y;
  assign in_area  = rtqs_pkg::box_area(in_box);
  assign busy     = (st_r != S_LOAD);
  assign accept   = start && !busy;
  assign room     = (cnt_r < CNT_W'(CAP));
  assign null_pkt = '0;
  assign last_pkt = chain[CAP];
  assign chain[0] = carry_r;

  always_comb begin
    ctl.seed  = (st_r == S_SMET) || (st_r == S_SRUN) || (st_r == S_SNEXT);
    ctl.probe = probe_r;
    ctl.x     = ctl.seed ? cbox[probe_r] : g1_r;
    ctl.y     = g2_r;
    ctl.k     = ctl.seed ? -WW'(carea[probe_r]) : (WW'(a2_r) - WW'(a1_r));
    for (int j = 0; j < CAP; j++) begin
      elig[j] = (CNT_W'(j) < n_r) &&
                (ctl.seed ? (IDX_W'(j) > probe_r) : !asg_r[j]);
    end
  end

  for (genvar j = 0; j < CAP; j++) begin : g_cell
    rtqs_cell u_cell (
      .clk     (clk),
      .wr_en   (accept && room && (cnt_r[IDX_W-1:0] == IDX_W'(j))),
      .wr_box  (in_box),
      .wr_area (in_area),
      .my_idx  (IDX_W'(j)),
      .elig    (elig[j]),
      .ctl     (ctl),
      .pkt_in  (chain[j]),
      .pkt_out (chain[j+1]),
      .box_o   (cbox[j]),
      .area_o  (carea[j])
    );
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    placed_nxt = placed_r;
    probe_nxt  = probe_r;
    cyc_nxt    = cyc_r;
    asg_nxt    = asg_r;
    carry_nxt  = carry_r;
    g1_nxt     = g1_r;
    g2_nxt     = g2_r;
    a1_nxt     = a1_r;
    a2_nxt     = a2_r;
    ov_nxt     = 1'b0;
    oidx_nxt   = oidx_r;
    otwo_nxt   = otwo_r;
    olast_nxt  = olast_r;
    ob1_nxt    = ob1_r;
    ob2_nxt    = ob2_r;
    jbox       = rtqs_pkg::box_join(last_pkt.bb, last_pkt.two ? g2_r : g1_r);
    unique case (st_r)
      S_LOAD: begin
        if (accept) begin
          cnt_nxt = cnt_r + CNT_W'(room);
          if (in_last_entry) begin
            n_nxt     = cnt_r + CNT_W'(room);
            probe_nxt = '0;
            carry_nxt = null_pkt;
            asg_nxt   = '0;
            st_nxt    = (cnt_r + CNT_W'(room) < CNT_W'(2)) ? S_ONE : S_SMET;
          end
        end
      end
      S_ONE: begin
        ov_nxt    = 1'b1;
        oidx_nxt  = '0;
        otwo_nxt  = 1'b0;
        olast_nxt = 1'b1;
        ob1_nxt   = cbox[0];
        ob2_nxt   = '0;
        cnt_nxt   = '0;
        st_nxt    = S_LOAD;
      end
      S_SMET: begin
        cyc_nxt = '0;
        st_nxt  = S_SRUN;
      end
      S_SRUN: begin
        cyc_nxt = cyc_r + IDX_W'(1);
        if (cyc_r == IDX_W'(CAP - 1)) begin
          st_nxt = S_SNEXT;
        end
      end
      S_SNEXT: begin
        carry_nxt = last_pkt;
        if (CNT_W'(probe_r) + CNT_W'(2) == n_r) begin
          st_nxt = S_SEED1;
        end else begin
          probe_nxt = probe_r + IDX_W'(1);
          st_nxt    = S_SMET;
        end
      end
      S_SEED1: begin
        g1_nxt             = carry_r.ba;
        g2_nxt             = carry_r.bb;
        asg_nxt[carry_r.ia] = 1'b1;
        ov_nxt    = 1'b1;
        oidx_nxt  = carry_r.ia;
        otwo_nxt  = 1'b0;
        olast_nxt = 1'b0;
        ob1_nxt   = carry_r.ba;
        ob2_nxt   = '0;
        st_nxt    = S_SEED2;
      end
      S_SEED2: begin
        asg_nxt[carry_r.ib] = 1'b1;
        placed_nxt = CNT_W'(2);
        ov_nxt     = 1'b1;
        oidx_nxt   = carry_r.ib;
        otwo_nxt   = 1'b1;
        olast_nxt  = (n_r == CNT_W'(2));
        ob1_nxt    = g1_r;
        ob2_nxt    = g2_r;
        if (n_r == CNT_W'(2)) begin
          cnt_nxt = '0;
          st_nxt  = S_LOAD;
        end else begin
          st_nxt = S_AAREA;
        end
      end
      S_AAREA: begin
        a1_nxt    = rtqs_pkg::box_area(g1_r);
        a2_nxt    = rtqs_pkg::box_area(g2_r);
        carry_nxt = null_pkt;
        st_nxt    = S_AMET;
      end
      S_AMET: begin
        cyc_nxt = '0;
        st_nxt  = S_ARUN;
      end
      S_ARUN: begin
        cyc_nxt = cyc_r + IDX_W'(1);
        if (cyc_r == IDX_W'(CAP - 1)) begin
          st_nxt = S_AEMIT;
        end
      end
      S_AEMIT: begin
        asg_nxt[last_pkt.ib] = 1'b1;
        placed_nxt = placed_r + CNT_W'(1);
        ov_nxt     = 1'b1;
        oidx_nxt   = last_pkt.ib;
        otwo_nxt   = last_pkt.two;
        olast_nxt  = (placed_r + CNT_W'(1) == n_r);
        if (last_pkt.two) begin
          g2_nxt  = jbox;
          ob1_nxt = g1_r;
          ob2_nxt = jbox;
        end else begin
          g1_nxt  = jbox;
          ob1_nxt = jbox;
          ob2_nxt = g2_r;
        end
        if (placed_r + CNT_W'(1) == n_r) begin
          cnt_nxt = '0;
          st_nxt  = S_LOAD;
        end else begin
          st_nxt = S_AAREA;
        end
      end
      default: begin
        st_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_LOAD;
      cnt_r <= '0;
      ov_r  <= 1'b0;
      asg_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
      asg_r <= asg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    placed_r <= placed_nxt;
    probe_r  <= probe_nxt;
    cyc_r    <= cyc_nxt;
    carry_r  <= carry_nxt;
    g1_r     <= g1_nxt;
    g2_r     <= g2_nxt;
    a1_r     <= a1_nxt;
    a2_r     <= a2_nxt;
    oidx_r   <= oidx_nxt;
    otwo_r   <= otwo_nxt;
    olast_r  <= olast_nxt;
    ob1_r    <= ob1_nxt;
    ob2_r    <= ob2_nxt;
  end

  assign out_valid        = ov_r;
  assign out_entry_index  = oidx_r;
  assign out_to_group_two = otwo_r;
  assign out_last_result  = olast_r;
  assign out_one_min_x    = ob1_r.min_x;
  assign out_one_min_y    = ob1_r.min_y;
  assign out_one_max_x    = ob1_r.max_x;
  assign out_one_max_y    = ob1_r.max_y;
  assign out_two_min_x    = ob2_r.min_x;
  assign out_two_min_y    = ob2_r.min_y;
  assign out_two_max_x    = ob2_r.max_x;
  assign out_two_max_y    = ob2_r.max_y;

endmodule
